// ===== src/pva_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_pkg
// shared types and constants of the polyphonic voice allocator
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int NUM_VOICES_DEF = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int AGE_W          = 32;
  localparam int PITCH_W        = 7;
  localparam int VEL_W          = 7;
  localparam int REQ_W          = 2;
  localparam int VIDX_W         = 4;
  localparam int RETRIG_W       = 2;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 2;

  // request types
  localparam logic [REQ_W-1:0] REQ_NOTE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // retrigger modes, anything at or above RETRIG_ANEW allocates anew
  localparam logic [RETRIG_W-1:0] RETRIG_OVERFLOW = 2'd0;
  localparam logic [RETRIG_W-1:0] RETRIG_RESEND   = 2'd1;
  localparam logic [RETRIG_W-1:0] RETRIG_ANEW     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEAL  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRIG = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_EMIT_A,
    ST_EMIT_B,
    ST_FL_CHECK,
    ST_FL_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic rd;
    logic idx_inc;
    logic decide;
    logic load_a;
    logic load_b;
    logic load_fl;
    logic zero;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic cur_busy;
    logic out_free;
    logic two;
    logic fl_last;
  } status_t;

endpackage

// ===== src/pva_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_ctrl
// sequencer: scan, decide, emit and flush steps of the voice allocator
// ----------------------------------------------------------------------------
module pva_ctrl
  import pva_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [REQ_W-1:0] req_type,
  input  status_t          st,
  output logic             in_stall,
  output cmd_t             cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && req_type == REQ_NOTE) begin
          state_next = ST_SCAN;
        end else if (in_valid && req_type == REQ_FLUSH) begin
          state_next = ST_FL_CHECK;
        end
      end
      ST_SCAN: begin
        if (st.scan_end) state_next = ST_DRAIN;
      end
      ST_DRAIN:  state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_EMIT_A;
      ST_EMIT_A: begin
        if (st.out_free) state_next = st.two ? ST_EMIT_B : ST_IDLE;
      end
      ST_EMIT_B: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      ST_FL_CHECK: begin
        if (st.cur_busy) begin
          state_next = ST_FL_EMIT;
        end else if (st.scan_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_FL_EMIT: begin
        if (st.out_free) state_next = st.fl_last ? ST_IDLE : ST_FL_CHECK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
        cmd.zero  = in_valid && req_type == REQ_CLEAR;
      end
      ST_SCAN: begin
        cmd.rd      = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      ST_DRAIN:  cmd = '0;
      ST_DECIDE: cmd.decide = 1'b1;
      ST_EMIT_A: cmd.load_a = st.out_free;
      ST_EMIT_B: cmd.load_b = st.out_free;
      ST_FL_CHECK: begin
        cmd.rd      = st.cur_busy;
        cmd.idx_inc = !st.cur_busy && !st.scan_end;
        cmd.zero    = !st.cur_busy && st.scan_end;
      end
      ST_FL_EMIT: begin
        cmd.load_fl = st.out_free;
        cmd.idx_inc = st.out_free && !st.fl_last;
        cmd.zero    = st.out_free && st.fl_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== src/pva_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_dp
// voice store, oldest-voice search, decision and output register
// ----------------------------------------------------------------------------
module pva_dp
  import pva_pkg::*;
#(
  parameter int NUM_VOICES = NUM_VOICES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             st,
  input  logic                steal_enable,
  input  logic [RETRIG_W-1:0] retrig_mode,
  input  logic [PITCH_W-1:0]  pitch,
  input  logic [VEL_W-1:0]    velocity,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VIDX_W-1:0]   voice_index,
  output logic                to_overflow,
  output logic [PITCH_W-1:0]  out_pitch,
  output logic [VEL_W-1:0]    out_velocity,
  output logic                last
);

  localparam int IW    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CNT_W = $clog2(MAX_RESULTS);

  function automatic logic [VIDX_W-1:0] to_vidx(input logic [IW-1:0] v);
    logic [IW+VIDX_W-1:0] w;
    w = {{VIDX_W{1'b0}}, v};
    return w[VIDX_W-1:0];
  endfunction

  // voice store
  logic [PITCH_W-1:0]    note_mem [NUM_VOICES];
  logic [AGE_W-1:0]      age_mem  [NUM_VOICES];
  logic [NUM_VOICES-1:0] busy;
  logic [NUM_VOICES-1:0] age_ok;
  logic [AGE_W-1:0]      age_counter;

  logic [PITCH_W-1:0] pitch_q;
  logic [VEL_W-1:0]   vel_q;
  logic [IW-1:0]      scan_idx;
  logic [CNT_W-1:0]   fl_cnt;

  // read pipe
  logic               rd_vld;
  logic [IW-1:0]      rd_idx;
  logic [PITCH_W-1:0] rd_note;
  logic [AGE_W-1:0]   rd_age;
  logic               rd_age_ok;
  logic [AGE_W-1:0]   cur_age;
  logic               cur_busy_rd;
  logic               cur_match;

  // search accumulators
  logic               bv, fv, hfv, hov;
  logic [IW-1:0]      bi, fi, hf, ho;
  logic [AGE_W-1:0]   ba, fa, ha;
  logic [PITCH_W-1:0] bn;

  // decision
  logic [IW-1:0]      d_idx;
  logic               d_ovf;
  logic [PITCH_W-1:0] d_pitch;
  logic [VEL_W-1:0]   d_vel;
  logic               d_two, d_wr, d_set, d_clr, d_stamp_rst;
  logic [IW-1:0]      d_wa;
  logic [IW-1:0]      a_idx;
  logic               a_ovf;
  logic [PITCH_W-1:0] a_pitch;
  logic [VEL_W-1:0]   a_vel;
  logic               two;

  logic [NUM_VOICES-1:0] ho_mask;
  logic [NUM_VOICES-1:0] le_mask;
  logic                  busy_above;
  logic                  fl_last;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_note <= note_mem[scan_idx];
      rd_age  <= age_mem[scan_idx];
    end
    if (cmd.decide && d_wr) begin
      note_mem[d_wa] <= pitch_q;
      age_mem[d_wa]  <= age_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_idx    <= scan_idx;
      rd_age_ok <= age_ok[scan_idx];
    end
    if (cmd.start) begin
      pitch_q <= pitch;
      vel_q   <= velocity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      scan_idx <= '0;
      fl_cnt   <= '0;
    end else begin
      rd_vld <= cmd.rd;
      if (cmd.start) begin
        scan_idx <= '0;
        fl_cnt   <= '0;
      end else if (cmd.idx_inc) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (cmd.load_fl) fl_cnt <= fl_cnt + 1'b1;
    end
  end

  assign cur_age     = rd_age_ok ? rd_age : '0;
  assign cur_busy_rd = busy[rd_idx];
  assign cur_match   = cur_busy_rd && rd_note == pitch_q;

  // oldest busy, oldest free, first match and oldest match, one voice a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      bv  <= 1'b0;
      fv  <= 1'b0;
      hfv <= 1'b0;
      hov <= 1'b0;
    end else if (cmd.start) begin
      bv  <= 1'b0;
      fv  <= 1'b0;
      hfv <= 1'b0;
      hov <= 1'b0;
    end else if (rd_vld) begin
      if (cur_busy_rd && (!bv || cur_age < ba)) bv <= 1'b1;
      if (!cur_busy_rd && (!fv || cur_age < fa)) fv <= 1'b1;
      if (cur_match) hfv <= 1'b1;
      if (cur_match && (!hov || cur_age < ha)) hov <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      if (cur_busy_rd && (!bv || cur_age < ba)) begin
        bi <= rd_idx;
        ba <= cur_age;
        bn <= rd_note;
      end
      if (!cur_busy_rd && (!fv || cur_age < fa)) begin
        fi <= rd_idx;
        fa <= cur_age;
      end
      if (cur_match && !hfv) hf <= rd_idx;
      if (cur_match && (!hov || cur_age < ha)) begin
        ho <= rd_idx;
        ha <= cur_age;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_VOICES; j++) begin
      ho_mask[j] = hov && (IW'(j) == ho);
      le_mask[j] = IW'(j) <= scan_idx;
    end
  end

  assign busy_above = |(busy & ~le_mask);
  assign fl_last    = (fl_cnt == CNT_W'(MAX_RESULTS - 1)) || !busy_above;

  always_comb begin
    d_idx       = '0;
    d_ovf       = 1'b0;
    d_pitch     = pitch_q;
    d_vel       = vel_q;
    d_two       = 1'b0;
    d_wr        = 1'b0;
    d_wa        = fi;
    d_set       = 1'b0;
    d_clr       = 1'b0;
    d_stamp_rst = 1'b0;
    if (vel_q != '0) begin
      if (retrig_mode < RETRIG_ANEW && hfv) begin
        if (retrig_mode == RETRIG_RESEND) begin
          d_idx = hf;
        end else begin
          d_ovf = 1'b1;
        end
      end else if (fv) begin
        d_idx = fi;
        d_wr  = 1'b1;
        d_set = 1'b1;
      end else if (steal_enable && bv) begin
        // note-off for the old pitch first, the new note-on follows
        d_idx   = bi;
        d_pitch = bn;
        d_vel   = '0;
        d_two   = 1'b1;
        d_wr    = 1'b1;
        d_wa    = bi;
      end else begin
        d_ovf = 1'b1;
      end
    end else begin
      if (hov) begin
        d_idx = ho;
        d_clr = 1'b1;
      end else begin
        d_ovf = 1'b1;
      end
      d_stamp_rst = (age_counter != '0) && ((busy & ~ho_mask) == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      a_idx   <= d_idx;
      a_ovf   <= d_ovf;
      a_pitch <= d_pitch;
      a_vel   <= d_vel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= '0;
      age_ok      <= '0;
      age_counter <= '0;
      two         <= 1'b0;
    end else if (cmd.zero) begin
      busy        <= '0;
      age_ok      <= '0;
      age_counter <= '0;
    end else if (cmd.decide) begin
      two <= d_two;
      if (d_set) busy[d_wa] <= 1'b1;
      if (d_clr) busy[ho] <= 1'b0;
      if (d_stamp_rst) begin
        age_ok      <= '0;
        age_counter <= '0;
      end else if (d_wr) begin
        age_ok[d_wa] <= 1'b1;
        age_counter  <= age_counter + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_a || cmd.load_b || cmd.load_fl) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      voice_index  <= to_vidx(a_idx);
      to_overflow  <= a_ovf;
      out_pitch    <= a_pitch;
      out_velocity <= a_vel;
      last         <= !two;
    end else if (cmd.load_b) begin
      voice_index  <= to_vidx(bi);
      to_overflow  <= 1'b0;
      out_pitch    <= pitch_q;
      out_velocity <= vel_q;
      last         <= 1'b1;
    end else if (cmd.load_fl) begin
      voice_index  <= to_vidx(scan_idx);
      to_overflow  <= 1'b0;
      out_pitch    <= rd_note;
      out_velocity <= '0;
      last         <= fl_last;
    end
  end

  assign st.scan_end = scan_idx == IW'(NUM_VOICES - 1);
  assign st.cur_busy = busy[scan_idx];
  assign st.out_free = !out_valid || !out_stall;
  assign st.two      = two;
  assign st.fl_last  = fl_last;

endmodule

// ===== src/poly_voice_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly_voice_allocator
// assigns note requests to a pool of voices, oldest-first with optional steal
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) takes one request: req_type, pitch,
//   velocity. output channel (out_valid / out_stall) gives up to sixteen
//   messages per request, the final one marked by last; clear, unknown
//   request types and a flush with no voice held give none.
//   a note request scans every voice through the note/age memory, one voice
//   per cycle, then drains, decides and emits its first message; a steal
//   emits a second message after that. the single read port of the voice
//   memory is why the scan takes the voices one at a time.
//   flush checks the voices in turn and emits a note-off for each busy one.
//   clear is done in the accept cycle and the next request can follow at once.
//   in_stall is high while a request is in work; the last message may still
//   sit in the output register while the next request is accepted.
//   a stalled receiver simply holds the message, the sequencer waits.
//   reset (rst, synchronous) frees all voices, zeroes the age stamps and the
//   counter, clears steal_enable and retrig_mode; no clearing pass is needed.
//   configuration is written through cfg_wr_en / cfg_index / cfg_data; the
//   user must write it only while no request is in work, unchecked by the block.
// ----------------------------------------------------------------------------
module poly_voice_allocator
  import pva_pkg::*;
#(
  parameter int NUM_VOICES = NUM_VOICES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [PITCH_W-1:0]    pitch,
  input  logic [VEL_W-1:0]      velocity,
  // message channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VIDX_W-1:0]     voice_index,
  output logic                  to_overflow,
  output logic [PITCH_W-1:0]    out_pitch,
  output logic [VEL_W-1:0]      out_velocity,
  output logic                  last
);

  logic                steal_enable;
  logic [RETRIG_W-1:0] retrig_mode;
  cmd_t                cmd;
  status_t             st;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      steal_enable <= 1'b0;
      retrig_mode  <= RETRIG_OVERFLOW;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_STEAL:  steal_enable <= cfg_data[0];
        CFG_RETRIG: retrig_mode  <= cfg_data[RETRIG_W-1:0];
        default:    steal_enable <= steal_enable;
      endcase
    end
  end

  // sequencer
  pva_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .st       (st),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // voice store, search and output register
  pva_dp #(
    .NUM_VOICES (NUM_VOICES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .steal_enable (steal_enable),
    .retrig_mode  (retrig_mode),
    .pitch        (pitch),
    .velocity     (velocity),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .voice_index  (voice_index),
    .to_overflow  (to_overflow),
    .out_pitch    (out_pitch),
    .out_velocity (out_velocity),
    .last         (last)
  );

`ifndef SYNTHESIS
  // a note or flush request closes the input in the cycle after its accept
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (req_type == REQ_NOTE || req_type == REQ_FLUSH))
      |=> in_stall)
    else $error("input open right after a note or flush request");

  // overflow messages always carry voice zero
  a_overflow_voice : assert property (@(posedge clk) disable iff (rst)
    (out_valid && to_overflow) |-> (voice_index == '0))
    else $error("overflow message with a nonzero voice");

  // a note-on is always the final message of its request
  a_note_on_last : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_velocity != '0) |-> last)
    else $error("note-on message not marked last");
`endif

endmodule

// ===== dv/pva_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_checker
// watches both channels of the voice allocator, predicts the messages of
// every accepted request from its own copy of the voice table and compares
// them in order with the messages the block hands out
// ----------------------------------------------------------------------------
module pva_checker
  import pva_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [PITCH_W-1:0]    pitch,
  input  logic [VEL_W-1:0]      velocity,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [VIDX_W-1:0]     voice_index,
  input  logic                  to_overflow,
  input  logic [PITCH_W-1:0]    out_pitch,
  input  logic [VEL_W-1:0]      out_velocity,
  input  logic                  last,
  output int                    fail_count,
  output int                    msg_pending,
  output int                    msg_checked
);

  typedef struct packed {
    logic [VIDX_W-1:0]  vidx;
    logic               ovf;
    logic [PITCH_W-1:0] note;
    logic [VEL_W-1:0]   vel;
    logic               fin;
  } voice_msg_t;

  // voice table as the block should hold it
  logic               held       [NUM_VOICES_DEF];
  logic [PITCH_W-1:0] held_pitch [NUM_VOICES_DEF];
  logic [AGE_W-1:0]   stamp      [NUM_VOICES_DEF];
  logic [AGE_W-1:0]   stamp_clock;
  logic               steal_on;
  logic [RETRIG_W-1:0] retrig_sel;

  voice_msg_t expected_msgs[$];
  int step_msgs;
  int errors = 0;
  int seen = 0;

  function automatic void add_msg(int v, logic ovf, logic [PITCH_W-1:0] p,
                                  logic [VEL_W-1:0] vel);
    voice_msg_t m;
    if (step_msgs >= MAX_RESULTS) return;
    m.vidx = v[VIDX_W-1:0];
    m.ovf  = ovf;
    m.note = p;
    m.vel  = vel;
    m.fin  = 1'b0;
    expected_msgs.push_back(m);
    step_msgs++;
  endfunction

  function automatic void wipe_voices();
    for (int i = 0; i < NUM_VOICES_DEF; i++) begin
      held[i]       = 1'b0;
      held_pitch[i] = '0;
      stamp[i]      = '0;
    end
    stamp_clock = '0;
  endfunction

  // oldest free voice, else steal the oldest busy one, else overflow
  function automatic void start_note(logic [PITCH_W-1:0] p, logic [VEL_W-1:0] vel);
    int busy_pick;
    int free_pick;
    logic [AGE_W-1:0] busy_age;
    logic [AGE_W-1:0] free_age;
    busy_pick = -1;
    free_pick = -1;
    busy_age  = '0;
    free_age  = '0;
    for (int i = 0; i < NUM_VOICES_DEF; i++) begin
      if (held[i]) begin
        if (busy_pick < 0 || stamp[i] < busy_age) begin
          busy_pick = i;
          busy_age  = stamp[i];
        end
      end else if (free_pick < 0 || stamp[i] < free_age) begin
        free_pick = i;
        free_age  = stamp[i];
      end
    end
    if (free_pick >= 0) begin
      held[free_pick]       = 1'b1;
      held_pitch[free_pick] = p;
      stamp[free_pick]      = stamp_clock;
      stamp_clock           = stamp_clock + 1;
      add_msg(free_pick, 1'b0, p, vel);
    end else if (steal_on && busy_pick >= 0) begin
      add_msg(busy_pick, 1'b0, held_pitch[busy_pick], '0);
      held_pitch[busy_pick] = p;
      add_msg(busy_pick, 1'b0, p, vel);
      stamp[busy_pick] = stamp_clock;
      stamp_clock      = stamp_clock + 1;
    end else begin
      add_msg(0, 1'b1, p, vel);
    end
  endfunction

  function automatic void note_request(logic [PITCH_W-1:0] p, logic [VEL_W-1:0] vel);
    int hit;
    logic [AGE_W-1:0] hit_age;
    logic any_held;
    hit      = -1;
    hit_age  = '0;
    any_held = 1'b0;
    if (vel != 0) begin
      if (retrig_sel >= RETRIG_ANEW) begin
        start_note(p, vel);
        return;
      end
      for (int i = 0; i < NUM_VOICES_DEF; i++)
        if (hit < 0 && held[i] && held_pitch[i] == p) hit = i;
      if (hit < 0) start_note(p, vel);
      else if (retrig_sel == RETRIG_RESEND) add_msg(hit, 1'b0, p, vel);
      else add_msg(0, 1'b1, p, vel);
      return;
    end
    // note-off: oldest voice holding the pitch
    for (int i = 0; i < NUM_VOICES_DEF; i++) begin
      if (held[i] && held_pitch[i] == p && (hit < 0 || stamp[i] < hit_age)) begin
        hit     = i;
        hit_age = stamp[i];
      end
    end
    if (hit >= 0) begin
      add_msg(hit, 1'b0, held_pitch[hit], '0);
      held[hit]       = 1'b0;
      held_pitch[hit] = '0;
    end else begin
      add_msg(0, 1'b1, p, '0);
    end
    if (stamp_clock != 0) begin
      for (int i = 0; i < NUM_VOICES_DEF; i++) any_held |= held[i];
      if (!any_held) begin
        for (int i = 0; i < NUM_VOICES_DEF; i++) stamp[i] = '0;
        stamp_clock = '0;
      end
    end
  endfunction

  function automatic void predict_request(logic [REQ_W-1:0] rt, logic [PITCH_W-1:0] p,
                                          logic [VEL_W-1:0] vel);
    voice_msg_t m;
    step_msgs = 0;
    case (rt)
      REQ_NOTE: note_request(p, vel);
      REQ_FLUSH: begin
        for (int i = 0; i < NUM_VOICES_DEF; i++)
          if (held[i]) add_msg(i, 1'b0, held_pitch[i], '0);
        wipe_voices();
      end
      REQ_CLEAR: wipe_voices();
      default: ;
    endcase
    if (step_msgs > 0) begin
      m = expected_msgs.pop_back();
      m.fin = 1'b1;
      expected_msgs.push_back(m);
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: mismatch on %s, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void compare_msg();
    voice_msg_t want;
    if (expected_msgs.size() == 0) begin
      $display("%0t: message with none expected, actual voice %0d ovf %0d",
               $time, voice_index, to_overflow);
      $display("  pitch %0d vel %0d last %0d", out_pitch, out_velocity, last);
      errors++;
      return;
    end
    want = expected_msgs.pop_front();
    seen++;
    check_field("voice_index", int'(want.vidx), int'(voice_index));
    check_field("to_overflow", int'(want.ovf), int'(to_overflow));
    check_field("out_pitch", int'(want.note), int'(out_pitch));
    check_field("out_velocity", int'(want.vel), int'(out_velocity));
    check_field("last", int'(want.fin), int'(last));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      wipe_voices();
      steal_on   = 1'b0;
      retrig_sel = RETRIG_OVERFLOW;
      expected_msgs.delete();
    end else begin
      // older messages leave before the new request is predicted
      if (out_valid && !out_stall) compare_msg();
      if (cfg_wr_en) begin
        if (cfg_index == CFG_STEAL) steal_on = cfg_data[0];
        else retrig_sel = cfg_data;
      end
      if (in_valid && !in_stall) predict_request(req_type, pitch, velocity);
    end
    fail_count  <= errors;
    msg_pending <= expected_msgs.size();
    msg_checked <= seen;
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the voice allocator: a short directed run through
// overflow, retrigger, steal, flush and clear, then random note traffic in
// phases under several register settings with random idling on both sides
// ----------------------------------------------------------------------------
module tb_top;
  import pva_pkg::*;

  // request type the block has no meaning for, and the retrigger code above
  // the last defined mode
  localparam logic [REQ_W-1:0]    REQ_UNUSED  = 2'd3;
  localparam logic [RETRIG_W-1:0] RETRIG_SAT  = 2'd3;

  localparam int DRAIN_CYCLES = 48;      // one note scan or an idle flush, with margin
  localparam int CYCLE_LIMIT  = 600000;  // several times the slowest legal run
  localparam int PHASE_REQS   = 28;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [REQ_W-1:0]      req_type;
  logic [PITCH_W-1:0]    pitch;
  logic [VEL_W-1:0]      velocity;
  logic                  out_valid;
  logic                  out_stall;
  logic [VIDX_W-1:0]     voice_index;
  logic                  to_overflow;
  logic [PITCH_W-1:0]    out_pitch;
  logic [VEL_W-1:0]      out_velocity;
  logic                  last;

  int fail_count;
  int msg_pending;
  int msg_checked;
  int sent = 0;          // requests handed over, ignored types not counted
  int settings = 0;      // register settings the run went through
  int cycle_cnt;
  logic no_idle = 1'b0;  // phases with back-to-back traffic on both sides

  poly_voice_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .pitch        (pitch),
    .velocity     (velocity),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .voice_index  (voice_index),
    .to_overflow  (to_overflow),
    .out_pitch    (out_pitch),
    .out_velocity (out_velocity),
    .last         (last)
  );

  pva_checker msg_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .pitch        (pitch),
    .velocity     (velocity),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .voice_index  (voice_index),
    .to_overflow  (to_overflow),
    .out_pitch    (out_pitch),
    .out_velocity (out_velocity),
    .last         (last),
    .fail_count   (fail_count),
    .msg_pending  (msg_pending),
    .msg_checked  (msg_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs or loses messages
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("run stopped after %0d cycles with %0d messages outstanding",
             cycle_cnt, msg_pending);
    $display("[poly_voice_allocator] ERROR");
    $finish;
  end

  // message receiver: per message a random stall, raised before the message shows up
  initial begin
    int hold;
    out_stall = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 17);
      out_stall <= (hold != 0);
      do @(posedge clk); while (!out_valid);
      // with no stall the message went through at this edge already
      if (hold != 0) begin
        repeat (hold - 1) @(posedge clk);
        out_stall <= 1'b0;
        do @(posedge clk); while (!(out_valid && !out_stall));
      end
    end
  end

  // one request: optional gap, then hold it until the block takes it;
  // valid stays high on return so a back-to-back request needs no toggle
  task automatic send_request(logic [REQ_W-1:0] rt, logic [PITCH_W-1:0] p,
                              logic [VEL_W-1:0] vel);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    pitch    <= p;
    velocity <= vel;
    do @(posedge clk); while (in_stall);
    if (rt != REQ_UNUSED) sent++;
  endtask

  // wait until every message is out, then give a silent flush time to end
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (msg_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // both registers, only while the block is idle; the spare data bit of the
  // steal register is random and must be dropped by the block
  task automatic set_config(logic steal, logic [RETRIG_W-1:0] retrig);
    logic spare;
    spare = 1'($urandom_range(0, 1));
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_STEAL;
    cfg_data  <= {spare, steal};
    @(posedge clk);
    cfg_index <= CFG_RETRIG;
    cfg_data  <= retrig;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  // any pitch and any velocity, for requests that ignore both
  function automatic logic [PITCH_W-1:0] any_pitch();
    return PITCH_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [VEL_W-1:0] any_vel();
    return VEL_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [VEL_W-1:0] on_vel();
    return VEL_W'($urandom_range(1, 127));
  endfunction

  // mostly a small pool of pitches so note-offs and retriggers find voices
  function automatic logic [PITCH_W-1:0] pick_pitch();
    if ($urandom_range(0, 7) == 0) return PITCH_W'($urandom_range(0, 127));
    return PITCH_W'(40 + $urandom_range(0, 19));
  endfunction

  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) send_request(REQ_UNUSED, any_pitch(), any_vel());
    else if (r < 4) send_request(REQ_FLUSH, any_pitch(), any_vel());
    else if (r < 6) send_request(REQ_CLEAR, any_pitch(), any_vel());
    else if (r < 62) send_request(REQ_NOTE, pick_pitch(), on_vel());
    else send_request(REQ_NOTE, pick_pitch(), '0);
  endtask

  // a burst of eight to eighteen note-ons can fill the pool, so steal and overflow
  // get exercised, then mixed traffic
  task automatic run_phase(logic steal, logic [RETRIG_W-1:0] retrig);
    int burst;
    int stop;
    set_config(steal, retrig);
    no_idle = ($urandom_range(0, 3) == 0);
    burst = $urandom_range(8, 18);
    stop  = sent + PHASE_REQS;
    repeat (burst) send_request(REQ_NOTE, pick_pitch(), on_vel());
    while (sent < stop) random_request();
    settle();
  endtask

  initial begin
    rst       = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_STEAL;
    cfg_data  = '0;
    in_valid  = 1'b0;
    req_type  = REQ_NOTE;
    pitch     = '0;
    velocity  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: no steal, a sounding pitch goes to overflow
    send_request(REQ_NOTE, 7'd0, 7'd127);
    send_request(REQ_NOTE, 7'd127, 7'd1);
    send_request(REQ_NOTE, 7'd0, 7'd64);      // already sounding
    send_request(REQ_NOTE, 7'd5, 7'd0);       // note-off nobody holds
    send_request(REQ_NOTE, 7'd0, 7'd0);       // frees voice 0
    send_request(REQ_CLEAR, 7'd127, 7'd127);  // drops the held top note silently
    send_request(REQ_FLUSH, 7'd127, 7'd127);  // nothing held, no message
    send_request(REQ_UNUSED, 7'd127, 7'd127); // ignored
    settle();

    // steal with resend: fill every voice, steal the oldest, retrigger one,
    // then flush all sixteen
    set_config(1'b1, RETRIG_RESEND);
    for (int i = 0; i < NUM_VOICES_DEF; i++)
      send_request(REQ_NOTE, PITCH_W'(20 + i), on_vel());
    send_request(REQ_NOTE, 7'd90, 7'd100);
    send_request(REQ_NOTE, 7'd21, 7'd127);
    send_request(REQ_FLUSH, 7'd0, 7'd0);
    settle();

    run_phase(1'b0, RETRIG_OVERFLOW);
    run_phase(1'b1, RETRIG_ANEW);
    run_phase(1'b0, RETRIG_RESEND);
    run_phase(1'b1, RETRIG_SAT);
    run_phase(1'b0, RETRIG_SAT);
    run_phase(1'b1, RETRIG_OVERFLOW);
    run_phase(1'b0, RETRIG_ANEW);

    $display("covered %0d requests over %0d register settings", sent, settings);
    $display("%0d messages compared, %0d mismatches", msg_checked, fail_count);
    if (fail_count == 0) begin
      $display("[poly_voice_allocator] OK");
    end else begin
      $display("[poly_voice_allocator] ERROR");
    end
    $finish;
  end

endmodule
